// ----- rtl/fccw_pkg.sv -----
// Shared types and constants of the FAT32 cluster chain walker.
`default_nettype none

package fccw_pkg;

  localparam int ENTRY_W = 28;
  localparam int RAW_W = 32;
  localparam int HC_W = 12;
  localparam int DEF_TABLE_ENTRIES = 4096;
  localparam int DEF_MAX_CHAIN = 64;
  localparam logic [HC_W-1:0] HC_RESET = 12'd4095;

  localparam logic [ENTRY_W-1:0] END_MARK_MIN = 28'hFFFFFF8;
  localparam logic [ENTRY_W-1:0] BAD_MARK = 28'hFFFFFF7;
  localparam logic [ENTRY_W-1:0] FREE_MARK = 28'h0000000;
  localparam logic [ENTRY_W-1:0] FIRST_CLUSTER = 28'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_WALK = 1'b1;

  typedef enum logic [2:0] {
    ST_END   = 3'd0,
    ST_BAD   = 3'd1,
    ST_FREE  = 3'd2,
    ST_RANGE = 3'd3,
    ST_LONG  = 3'd4,
    ST_START = 3'd5
  } status_t;

  typedef struct packed {
    logic ok;
    logic end_mark;
    logic bad_mark;
    logic free;
  } cls_t;

endpackage

`default_nettype wire

// ----- rtl/fccw_if.sv -----
// Request and result channel interfaces of the chain walker.
`default_nettype none

interface fccw_req_if;
  import fccw_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [ENTRY_W-1:0] cluster;
  logic [RAW_W-1:0]   entry_value;
  modport source(output valid, req_type, cluster, entry_value, input ready);
  modport sink(input valid, req_type, cluster, entry_value, output ready);
endinterface

interface fccw_res_if;
  import fccw_pkg::*;
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] chain_cluster;
  logic               last;
  logic [2:0]         end_status;
  modport source(output valid, chain_cluster, last, end_status, input ready);
  modport sink(input valid, chain_cluster, last, end_status, output ready);
endinterface

`default_nettype wire

// ----- rtl/fccw_table.sv -----
// Allocation table memory with one write port and one registered read port.
`default_nettype none

module fccw_table #(
  parameter int ENTRIES = fccw_pkg::DEF_TABLE_ENTRIES,
  localparam int AW = $clog2(ENTRIES)
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic [fccw_pkg::ENTRY_W-1:0] wr_data,
  input  wire logic                         rd_en,
  input  wire logic [AW-1:0]                rd_addr,
  output logic      [fccw_pkg::ENTRY_W-1:0] rd_data
);
  import fccw_pkg::*;

  logic [ENTRY_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fccw_classify.sv -----
// Shared compare unit that classifies a start cluster or a table entry.
`default_nettype none

module fccw_classify #(
  parameter int TABLE_ENTRIES = fccw_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic [fccw_pkg::ENTRY_W-1:0] value,
  input  wire logic [fccw_pkg::HC_W-1:0]    highest,
  output fccw_pkg::cls_t                    cls
);
  import fccw_pkg::*;

  localparam logic [ENTRY_W-1:0] LIMIT = ENTRY_W'(TABLE_ENTRIES);

  logic [ENTRY_W-1:0] highest_ext;

  assign highest_ext = {{(ENTRY_W-HC_W){1'b0}}, highest};

  always_comb begin
    cls.ok       = (value >= FIRST_CLUSTER) && (value <= highest_ext) && (value < LIMIT);
    cls.end_mark = value >= END_MARK_MIN;
    cls.bad_mark = value == BAD_MARK;
    cls.free     = value == FREE_MARK;
  end

endmodule

`default_nettype wire

// ----- rtl/fat32_cluster_chain_walker.sv -----
// Top level of the FAT32 cluster chain walker.
// A table write produces no result.
// A walk's first result passes through the cur and output registers after acceptance, and then
// one result per cycle follows while results are taken; the single registered read port of
// the table, one link per cycle, sets that pace.
// Reset sets highest_cluster to 4095 and idles the sequencer; the table is not cleared.
`default_nettype none

module fat32_cluster_chain_walker #(
  parameter int TABLE_ENTRIES = fccw_pkg::DEF_TABLE_ENTRIES,
  parameter int MAX_CHAIN = fccw_pkg::DEF_MAX_CHAIN
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [fccw_pkg::HC_W-1:0] cfg_wdata,
  fccw_req_if.sink                       req,
  fccw_res_if.source                     res
);
  import fccw_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(MAX_CHAIN);
  localparam logic [ENTRY_W-1:0] LIMIT = ENTRY_W'(TABLE_ENTRIES);
  localparam logic [CW-1:0] CNT_CAP = CW'(MAX_CHAIN - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_START = 3'b100
  } state_t;

  state_t             state;
  logic [HC_W-1:0]    highest_cluster;
  logic [ENTRY_W-1:0] cur;
  logic [CW-1:0]      cnt;
  logic               out_valid;
  logic [ENTRY_W-1:0] out_cluster;
  logic               out_last;
  status_t            out_status;

  logic               accept;
  logic               is_walk;
  logic               slot_free;
  logic               stop;
  status_t            stop_status;
  logic               advance;
  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] cls_in;
  cls_t               cls;

  assign req.ready = state == S_IDLE;
  assign accept    = req.valid && req.ready;
  assign is_walk   = req.req_type == REQ_WALK;
  assign slot_free = !out_valid || res.ready;
  assign wr_en     = accept && !is_walk && (req.cluster < LIMIT);

  assign cls_in = (state == S_CHECK) ? rd_data : req.cluster;

  fccw_classify #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_classify (
    .value  (cls_in),
    .highest(highest_cluster),
    .cls    (cls)
  );

  always_comb begin
    stop = 1'b1;
    stop_status = ST_END;
    if (cls.end_mark) begin
      stop_status = ST_END;
    end else if (cls.bad_mark) begin
      stop_status = ST_BAD;
    end else if (cls.free) begin
      stop_status = ST_FREE;
    end else if (!cls.ok) begin
      stop_status = ST_RANGE;
    end else if (cnt == CNT_CAP) begin
      stop_status = ST_LONG;
    end else begin
      stop = 1'b0;
    end
  end

  assign advance = (state == S_CHECK) && slot_free && !stop;
  assign rd_en   = (accept && is_walk && cls.ok) || advance;
  assign rd_addr = advance ? rd_data[AW-1:0] : req.cluster[AW-1:0];

  fccw_table #(
    .ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(req.cluster[AW-1:0]),
    .wr_data(req.entry_value[ENTRY_W-1:0]),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_cluster <= HC_RESET;
    end else if (cfg_we) begin
      highest_cluster <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && is_walk) begin
            cnt <= '0;
            state <= cls.ok ? S_CHECK : S_START;
          end
        end
        S_CHECK: begin
          if (slot_free) begin
            if (stop) begin
              state <= S_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_START: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_walk) begin
      cur <= req.cluster;
    end else if (advance) begin
      cur <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= (state == S_CHECK) || (state == S_START);
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_cluster <= cur;
      if (state == S_START) begin
        out_last <= 1'b1;
        out_status <= ST_START;
      end else begin
        out_last <= stop;
        out_status <= stop ? stop_status : ST_END;
      end
    end
  end

  assign res.valid         = out_valid;
  assign res.chain_cluster = out_cluster;
  assign res.last          = out_last;
  assign res.end_status    = out_status;

  a_onehot_state: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state is not one-hot");

  a_busy_after_walk: assert property (@(posedge clk) disable iff (rst)
    accept && is_walk |=> !req.ready)
    else $error("walk request accepted but block stayed ready");

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.last |-> res.end_status == ST_END)
    else $error("status set on a result that is not last");

  a_cap_respected: assert property (@(posedge clk) disable iff (rst)
    advance |-> cnt != CNT_CAP)
    else $error("walk continued past the chain length cap");

endmodule

`default_nettype wire
